FILE: hdl/rjac_pkg.sv
package rjac_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUO_W_DEF     = DATA_W + 1;
  localparam int SQ_IN_W       = 2 * DATA_W;
  localparam int IN_W          = 4 * DATA_W;
  localparam int OUT_FIELDS    = 6;
  localparam int OUT_W         = ((OUT_FIELDS * DATA_W + 1 + 7) / 8) * 8;

  localparam logic [DATA_W-1:0] LIMIT_RST = 32'd42950;
  localparam logic [DATA_W-1:0] SAT_POS   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG   = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

FILE: hdl/radar_measurement_jacobian.sv
// Throughput: one item per cycle unless stalled; all stages pipelined, with the
// square root resolving one root bit per stage after a load stage (33 stages)
// and each divider one quotient bit per stage after a load stage (34 stages).
// Output backpressure stalls the whole pipeline in place.
// Reset clears all valid bits and loads near_zero_limit with 42950.
module radar_measurement_jacobian
  import rjac_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, vel_x, vel_y
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // range_by_px, range_by_py, bearing_by_px, bearing_by_py, rate_by_px,
  // rate_by_py, divide_fault, zero pad
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int W     = DATA_W;
  localparam int C_W   = 2 * W;
  localparam int P_W   = 3 * W;
  localparam int N0_W  = W + FRAC_BITS;
  localparam int N2_W  = W + 2 * FRAC_BITS;
  localparam int N4_W  = P_W + FRAC_BITS;
  localparam int SB_W  = C_W + W + W + C_W + 5;
  localparam int PAD_W = OUT_W - OUT_FIELDS * W - 1;
  localparam logic REG_NEAR_ZERO_LIMIT = 1'b0;

  function automatic logic [W-1:0] sat_pack(input logic neg, input logic ovf,
                                            input logic [QUO_W_DEF-1:0] q);
    logic [QUO_W_DEF-1:0] nq;
    nq = '0 - q;
    if (neg) begin
      sat_pack = (ovf || q > {1'b0, SAT_NEG}) ? SAT_NEG : nq[W-1:0];
    end else begin
      sat_pack = (ovf || q > {1'b0, SAT_POS}) ? SAT_POS : q[W-1:0];
    end
  endfunction

  // configuration
  logic [W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_NEAR_ZERO_LIMIT) begin
      limit_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEAR_ZERO_LIMIT) ? limit_q : '0;

  // pipeline enable
  logic en;
  logic m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: input register
  logic         v1_q;
  logic [W-1:0] p1_q, q1_q, vx1_q, vy1_q;
  logic [W-1:0] mp1, mq1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= s_axis_tdata[W-1:0];
      q1_q  <= s_axis_tdata[2*W-1:W];
      vx1_q <= s_axis_tdata[3*W-1:2*W];
      vy1_q <= s_axis_tdata[4*W-1:3*W];
    end
  end

  assign mp1 = p1_q[W-1] ? ('0 - p1_q) : p1_q;
  assign mq1 = q1_q[W-1] ? ('0 - q1_q) : q1_q;

  // stage 2: squares and cross products
  logic                  v2_q;
  logic [C_W-1:0]        mpsq2_q, mqsq2_q;
  logic signed [C_W-1:0] a2_q, b2_q;
  logic [W-1:0]          mp2_q, mq2_q;
  logic                  pneg2_q, qneg2_q, qpos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mpsq2_q <= C_W'(mp1) * C_W'(mp1);
      mqsq2_q <= C_W'(mq1) * C_W'(mq1);
      a2_q    <= $signed(q1_q) * $signed(vx1_q);
      b2_q    <= $signed(p1_q) * $signed(vy1_q);
      mp2_q   <= mp1;
      mq2_q   <= mq1;
      pneg2_q <= p1_q[W-1];
      qneg2_q <= q1_q[W-1];
      qpos2_q <= !q1_q[W-1] && (q1_q != '0);
    end
  end

  // stage 3: c1, fault, cross difference; registered at the root input
  logic [C_W-1:0]  c3, dm3;
  logic            fault3, dneg3;
  logic [SB_W-1:0] sb3;

  assign c3     = mpsq2_q + mqsq2_q;
  assign fault3 = (c3 < C_W'(limit_q)) || (c3 == '0);
  assign dneg3  = a2_q < b2_q;
  assign dm3    = dneg3 ? C_W'(b2_q - a2_q) : C_W'(a2_q - b2_q);
  assign sb3    = {c3, mp2_q, mq2_q, dm3, dneg3, pneg2_q, qneg2_q, qpos2_q, fault3};

  logic            vsq;
  logic [W-1:0]    root_sq;
  logic [SB_W-1:0] sb_sq;

  rjac_sqrt #(
    .X_W  (C_W),
    .SB_W (SB_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v2_q),
    .x_i    (c3),
    .sb_i   (sb3),
    .vld_o  (vsq),
    .root_o (root_sq),
    .sb_o   (sb_sq)
  );

  logic [C_W-1:0] c4, dm4;
  logic [W-1:0]   mp4, mq4;
  logic           dneg4, pneg4, qneg4, qpos4, fault4;

  assign {c4, mp4, mq4, dm4, dneg4, pneg4, qneg4, qpos4, fault4} = sb_sq;

  // stage 4: partial products
  logic           v4_q;
  logic [C_W-1:0] cslo4_q, cshi4_q, mqlo4_q, mqhi4_q, mplo4_q, mphi4_q;
  logic [W-1:0]   s4_q, mp4_q, mq4_q;
  logic [C_W-1:0] c4_q;
  logic           fault4_q, pneg4_q, qneg4_q, qpos4_q, rneg4_q, sneg4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vsq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cslo4_q  <= C_W'(c4[W-1:0]) * C_W'(root_sq);
      cshi4_q  <= C_W'(c4[C_W-1:W]) * C_W'(root_sq);
      mqlo4_q  <= C_W'(mq4) * C_W'(dm4[W-1:0]);
      mqhi4_q  <= C_W'(mq4) * C_W'(dm4[C_W-1:W]);
      mplo4_q  <= C_W'(mp4) * C_W'(dm4[W-1:0]);
      mphi4_q  <= C_W'(mp4) * C_W'(dm4[C_W-1:W]);
      s4_q     <= root_sq;
      c4_q     <= c4;
      mp4_q    <= mp4;
      mq4_q    <= mq4;
      fault4_q <= fault4;
      pneg4_q  <= pneg4;
      qneg4_q  <= qneg4;
      qpos4_q  <= qpos4;
      rneg4_q  <= (dm4 != '0) && (mq4 != '0) && (qneg4 != dneg4);
      sneg4_q  <= (dm4 != '0) && (mp4 != '0) && (pneg4 == dneg4);
    end
  end

  // stage 5: partial product sums
  logic           v5_q;
  logic [P_W-1:0] den5_q, nq5_q, np5_q;
  logic [W-1:0]   s5_q, mp5_q, mq5_q;
  logic [C_W-1:0] c5_q;
  logic           fault5_q, pneg5_q, qneg5_q, qpos5_q, rneg5_q, sneg5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den5_q   <= P_W'(cslo4_q) + {cshi4_q, {W{1'b0}}};
      nq5_q    <= P_W'(mqlo4_q) + {mqhi4_q, {W{1'b0}}};
      np5_q    <= P_W'(mplo4_q) + {mphi4_q, {W{1'b0}}};
      s5_q     <= s4_q;
      c5_q     <= c4_q;
      mp5_q    <= mp4_q;
      mq5_q    <= mq4_q;
      fault5_q <= fault4_q;
      pneg5_q  <= pneg4_q;
      qneg5_q  <= qneg4_q;
      qpos5_q  <= qpos4_q;
      rneg5_q  <= rneg4_q;
      sneg5_q  <= sneg4_q;
    end
  end

  // dividers
  logic [OUT_FIELDS-1:0] dv, ovf, neg;
  logic [QUO_W_DEF-1:0]  quo [0:OUT_FIELDS-1];
  logic                  fault_d;

  rjac_div #(.NUM_W(N0_W), .DEN_W(W), .SB_W(2)) u_div_rpx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(v5_q),
    .num_i({mp5_q, {FRAC_BITS{1'b0}}}), .den_i(s5_q), .sb_i({fault5_q, pneg5_q}),
    .vld_o(dv[0]), .ovf_o(ovf[0]), .quo_o(quo[0]), .sb_o({fault_d, neg[0]})
  );

  rjac_div #(.NUM_W(N0_W), .DEN_W(W), .SB_W(1)) u_div_rpy (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(v5_q),
    .num_i({mq5_q, {FRAC_BITS{1'b0}}}), .den_i(s5_q), .sb_i(qneg5_q),
    .vld_o(dv[1]), .ovf_o(ovf[1]), .quo_o(quo[1]), .sb_o(neg[1])
  );

  rjac_div #(.NUM_W(N2_W), .DEN_W(C_W), .SB_W(1)) u_div_bpx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(v5_q),
    .num_i({mq5_q, {(2*FRAC_BITS){1'b0}}}), .den_i(c5_q), .sb_i(qpos5_q),
    .vld_o(dv[2]), .ovf_o(ovf[2]), .quo_o(quo[2]), .sb_o(neg[2])
  );

  rjac_div #(.NUM_W(N2_W), .DEN_W(C_W), .SB_W(1)) u_div_bpy (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(v5_q),
    .num_i({mp5_q, {(2*FRAC_BITS){1'b0}}}), .den_i(c5_q), .sb_i(pneg5_q),
    .vld_o(dv[3]), .ovf_o(ovf[3]), .quo_o(quo[3]), .sb_o(neg[3])
  );

  rjac_div #(.NUM_W(N4_W), .DEN_W(P_W), .SB_W(1)) u_div_ppx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(v5_q),
    .num_i({nq5_q, {FRAC_BITS{1'b0}}}), .den_i(den5_q), .sb_i(rneg5_q),
    .vld_o(dv[4]), .ovf_o(ovf[4]), .quo_o(quo[4]), .sb_o(neg[4])
  );

  rjac_div #(.NUM_W(N4_W), .DEN_W(P_W), .SB_W(1)) u_div_ppy (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(v5_q),
    .num_i({np5_q, {FRAC_BITS{1'b0}}}), .den_i(den5_q), .sb_i(sneg5_q),
    .vld_o(dv[5]), .ovf_o(ovf[5]), .quo_o(quo[5]), .sb_o(neg[5])
  );

  // output register
  logic [OUT_FIELDS*W-1:0] fields;
  logic [OUT_W-1:0]        m_data_d;

  always_comb begin
    for (int k = 0; k < OUT_FIELDS; k++) begin
      fields[k*W +: W] = fault_d ? '0 : sat_pack(neg[k], ovf[k], quo[k]);
    end
  end

  assign m_data_d = {{PAD_W{1'b0}}, fault_d, fields};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv == {OUT_FIELDS{dv[0]}})
    else $error("divider valid chains out of step");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[OUT_FIELDS*W] |-> m_data_q[OUT_FIELDS*W-1:0] == '0)
    else $error("fault result carries nonzero entries");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(en) && $past(dv[0]))
    else $error("result appeared without a pipeline transfer");
`endif

endmodule

FILE: hdl/rjac_sqrt.sv
module rjac_sqrt
  import rjac_pkg::*;
#(
  parameter int X_W  = SQ_IN_W,
  parameter int SB_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [X_W-1:0]   x_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             vld_o,
  output logic [X_W/2-1:0] root_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int R_W   = X_W / 2;
  localparam int STEPS = R_W;
  localparam int REM_W = R_W + 2;

  logic [REM_W-1:0] rem_q  [0:STEPS];
  logic [R_W-1:0]   root_q [0:STEPS];
  logic [X_W-1:0]   xs_q   [0:STEPS];
  logic [SB_W-1:0]  sb_q   [0:STEPS];
  logic [STEPS:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      xs_q[0]   <= x_i;
      sb_q[0]   <= sb_i;
    end
  end

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [REM_W+1:0] rr;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    assign rr    = {rem_q[j], xs_q[j][X_W-1 -: 2]};
    assign trial = {2'b00, root_q[j], 2'b01};
    assign ge    = rr >= trial;
    assign diff  = rr - trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? diff[REM_W-1:0] : rr[REM_W-1:0];
        root_q[j+1] <= {root_q[j][R_W-2:0], ge};
        xs_q[j+1]   <= {xs_q[j][X_W-3:0], 2'b00};
        sb_q[j+1]   <= sb_q[j];
      end
    end
  end

  assign vld_o  = vld_q[STEPS];
  assign root_o = root_q[STEPS];
  assign sb_o   = sb_q[STEPS];

endmodule

FILE: hdl/rjac_div.sv
module rjac_div
  import rjac_pkg::*;
#(
  parameter int NUM_W = 48,
  parameter int DEN_W = DATA_W,
  parameter int QUO_W = QUO_W_DEF,
  parameter int SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             vld_o,
  output logic             ovf_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0] r_q   [0:QUO_W];
  logic [DEN_W-1:0] d_q   [0:QUO_W];
  logic [QUO_W-1:0] lo_q  [0:QUO_W];
  logic [QUO_W-1:0] q_q   [0:QUO_W];
  logic [SB_W-1:0]  sb_q  [0:QUO_W];
  logic [QUO_W:0]   ovf_q;
  logic [QUO_W:0]   vld_q;
  logic [HI_W-1:0]  hi;

  assign hi = num_i[NUM_W-1:QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-1:0], vld_i};
    end
  end

  // quotient at or above 2^QUO_W flagged up front
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= DEN_W'(hi);
      d_q[0]   <= den_i;
      lo_q[0]  <= num_i[QUO_W-1:0];
      q_q[0]   <= '0;
      sb_q[0]  <= sb_i;
      ovf_q[0] <= CMP_W'(hi) >= CMP_W'(den_i);
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [DEN_W:0] rr;
    logic [DEN_W:0] dd;
    logic [DEN_W:0] diff;
    logic           ge;

    assign rr   = {r_q[j], lo_q[j][QUO_W-1]};
    assign dd   = {1'b0, d_q[j]};
    assign ge   = rr >= dd;
    assign diff = rr - dd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1]   <= ge ? diff[DEN_W-1:0] : rr[DEN_W-1:0];
        d_q[j+1]   <= d_q[j];
        lo_q[j+1]  <= {lo_q[j][QUO_W-2:0], 1'b0};
        q_q[j+1]   <= {q_q[j][QUO_W-2:0], ge};
        sb_q[j+1]  <= sb_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  assign vld_o = vld_q[QUO_W];
  assign ovf_o = ovf_q[QUO_W];
  assign quo_o = q_q[QUO_W];
  assign sb_o  = sb_q[QUO_W];

endmodule
